>>> design/tsra_pkg.sv
// Shared types, widths and codes of the time slot ring allocator.
`default_nettype none

package tsra_pkg;

    // Ring and channel limits.
    localparam int MAX_SLOTS = 512;
    localparam int MAX_FREQS = 1024;

    // Derived widths.
    localparam int ADDR_W  = $clog2(MAX_SLOTS);
    localparam int SIZE_W  = $clog2(MAX_SLOTS + 1);
    localparam int FREQ_W  = $clog2(MAX_FREQS);

    // Field widths of the stream items and registers.
    localparam int TS_W    = 64;
    localparam int FIN_W   = 10;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 9;
    localparam int FIDX_W  = 19;
    localparam int WCNT_W  = 32;
    localparam int SIU_W   = 10;
    localparam int FCNT_W  = 11;
    localparam int PROD_W  = ADDR_W + FCNT_W;

    // Stream and configuration port widths.
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = STAT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FCNT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_COUNT   = 2'd1;

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPT   = 2'd0,
        ST_DROP_OLD = 2'd1,
        ST_DROP_IN  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ES_CLEAR,
        ES_IDLE,
        ES_SCAN,
        ES_DECIDE,
        ES_EMIT
    } t_eng_state;

    // One word of the slot memory.
    typedef struct packed {
        logic            valid;
        logic [TS_W-1:0] stamp;
    } t_slot_word;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [SIZE_W-1:0] ring_size;
        logic [FCNT_W-1:0] freq_count;
    } t_cfg;

    // Outcome of one item, handed from the engine to the result stage.
    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  slot;
        logic [FIN_W-1:0]   freq;
        logic               clear;
        logic [WCNT_W-1:0]  wcount;
    } t_dec;

endpackage

`default_nettype wire

>>> design/tsra_cfg_regs.sv
// Configuration registers and the clamped ring size.
`default_nettype none

module tsra_cfg_regs
    import tsra_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    logic [SIU_W-1:0]  r_slots_in_use;
    logic [FCNT_W-1:0] r_freq_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= SIU_W'(512);
            r_freq_count   <= FCNT_W'(1024);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SLOTS_IN_USE: r_slots_in_use <= i_cfg_data[SIU_W-1:0];
                REG_FREQ_COUNT:   r_freq_count   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A ring size of zero acts as one, anything above the ring depth as the depth.
    always_comb begin
        if (r_slots_in_use == '0) begin
            o_cfg.ring_size = SIZE_W'(1);
        end else if (32'(r_slots_in_use) > MAX_SLOTS) begin
            o_cfg.ring_size = SIZE_W'(MAX_SLOTS);
        end else begin
            o_cfg.ring_size = SIZE_W'(r_slots_in_use);
        end
        o_cfg.freq_count = r_freq_count;
    end

endmodule

`default_nettype wire

>>> design/tsra_engine.sv
// Slot memory with the clearing sweep, the per-item scan and the slot decision.
`default_nettype none

module tsra_engine
    import tsra_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [TS_W-1:0]   i_stamp,
    input  wire logic [FIN_W-1:0]  i_freq,
    output logic                   o_dec_valid,
    input  wire logic              i_dec_ready,
    output t_dec                   o_dec
);

    t_eng_state r_state, n_state;

    t_slot_word r_mem [MAX_SLOTS];
    t_slot_word r_q;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_slot_word        mem_wdata;
    logic              rd_en;

    // Address counter for the sweep and the scan; one bit wider to reach the depth.
    logic [ADDR_W:0]   r_raddr;
    logic              r_cvld;
    logic [ADDR_W-1:0] r_caddr;

    // Item under work.
    logic [TS_W-1:0]   r_stamp;
    logic [FIN_W-1:0]  r_freq;
    logic [SIZE_W-1:0] r_size;

    // Scan results.
    logic              r_found;
    logic [ADDR_W-1:0] r_match;
    logic              r_free_found;
    logic [ADDR_W-1:0] r_free;
    logic              r_seen;
    logic [TS_W-1:0]   r_min;
    logic [TS_W-1:0]   r_max;
    logic [ADDR_W-1:0] r_oldest;

    logic [SIZE_W-1:0] r_held;
    logic [WCNT_W-1:0] r_writes;
    t_dec              r_dec;

    t_dec              n_dec;
    logic              dec_insert;
    logic              dec_evict;

    logic              in_acc;
    logic              scan_done;

    assign in_acc    = i_in_valid && o_in_ready;
    assign scan_done = (r_raddr == (ADDR_W+1)'(MAX_SLOTS)) && !r_cvld;

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= r_mem[r_raddr[ADDR_W-1:0]];
    end

    // Decision for the item once the whole ring has been scanned.
    always_comb begin
        n_dec.freq = r_freq;
        n_dec.slot = '0;
        n_dec.clear = 1'b0;
        n_dec.status = ST_ACCEPT;
        n_dec.wcount = r_writes;
        dec_insert = 1'b0;
        dec_evict = 1'b0;
        if (r_found) begin
            n_dec.slot = r_match;
            n_dec.wcount = r_writes + 1'b1;
        end else if (r_held < r_size) begin
            dec_insert = 1'b1;
            n_dec.slot = r_free_found ? r_free : '0;
            n_dec.wcount = r_writes + 1'b1;
        end else if (r_stamp < r_min) begin
            n_dec.status = ST_DROP_OLD;
        end else if (r_stamp > r_max) begin
            dec_evict = 1'b1;
            n_dec.slot = r_oldest;
            n_dec.clear = 1'b1;
            n_dec.wcount = r_writes + 1'b1;
        end else begin
            n_dec.status = ST_DROP_IN;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ES_CLEAR:  if (r_raddr == (ADDR_W+1)'(MAX_SLOTS - 1)) n_state = ES_IDLE;
            ES_IDLE:   if (in_acc) n_state = ES_SCAN;
            ES_SCAN:   if (scan_done) n_state = ES_DECIDE;
            ES_DECIDE: n_state = ES_EMIT;
            ES_EMIT:   if (i_dec_ready) n_state = ES_IDLE;
            default:   n_state = ES_CLEAR;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_raddr[ADDR_W-1:0];
        mem_wdata   = '0;
        rd_en       = 1'b0;
        o_in_ready  = 1'b0;
        o_dec_valid = 1'b0;
        case (r_state)
            ES_CLEAR: begin
                mem_we = 1'b1;
            end
            ES_IDLE: begin
                o_in_ready = 1'b1;
            end
            ES_SCAN: begin
                rd_en = (r_raddr < (ADDR_W+1)'(MAX_SLOTS));
            end
            ES_DECIDE: begin
                mem_we          = dec_insert || dec_evict;
                mem_waddr       = n_dec.slot;
                mem_wdata.stamp = r_stamp;
                // An evicted entry keeps its valid bit; it is set unless the ring is empty.
                mem_wdata.valid = dec_insert || r_seen;
            end
            ES_EMIT: begin
                o_dec_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ES_CLEAR;
            r_raddr  <= '0;
            r_cvld   <= 1'b0;
            r_held   <= '0;
            r_writes <= '0;
        end else begin
            r_state <= n_state;
            r_cvld  <= rd_en;
            if (r_state == ES_CLEAR || rd_en) begin
                r_raddr <= r_raddr + 1'b1;
            end else if (in_acc) begin
                r_raddr <= '0;
            end
            if (r_state == ES_DECIDE) begin
                if (dec_insert) begin
                    r_held <= r_held + 1'b1;
                end
                r_writes <= n_dec.wcount;
            end
        end
    end

    // Item capture and scan accumulation.
    always_ff @(posedge i_clk) begin
        r_caddr <= r_raddr[ADDR_W-1:0];
        if (in_acc) begin
            r_stamp      <= i_stamp;
            r_freq       <= i_freq;
            r_size       <= i_cfg.ring_size;
            r_found      <= 1'b0;
            r_match      <= '0;
            r_free_found <= 1'b0;
            r_free       <= '0;
            r_seen       <= 1'b0;
            r_min        <= '0;
            r_max        <= '0;
            r_oldest     <= '0;
        end else if (r_state == ES_SCAN && r_cvld) begin
            if (r_q.valid) begin
                if (r_q.stamp == r_stamp && !r_found) begin
                    r_found <= 1'b1;
                    r_match <= r_caddr;
                end
                if (!r_seen || r_q.stamp < r_min) begin
                    r_min    <= r_q.stamp;
                    r_oldest <= r_caddr;
                end
                if (!r_seen || r_q.stamp > r_max) begin
                    r_max <= r_q.stamp;
                end
                r_seen <= 1'b1;
            end else if (!r_free_found && SIZE_W'(r_caddr) < r_size) begin
                r_free_found <= 1'b1;
                r_free       <= r_caddr;
            end
        end
        if (r_state == ES_DECIDE) begin
            r_dec <= n_dec;
        end
    end

    assign o_dec = r_dec;

endmodule

`default_nettype wire

>>> design/tsra_result.sv
// Frame index arithmetic and the output register of the result stream.
`default_nettype none

module tsra_result
    import tsra_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [FCNT_W-1:0]      i_freq_count,
    input  wire logic                   i_dec_valid,
    output logic                        o_dec_ready,
    input  wire t_dec                   i_dec,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [OUT_DATA_W-1:0]       o_data,
    output logic [OUT_USER_W-1:0]       o_user
);

    logic              r_p_valid;
    t_dec              r_p_dec;
    logic [PROD_W-1:0] r_prod;

    logic                  r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic [OUT_USER_W-1:0] r_o_user;

    logic              move;
    logic              accepted;
    logic [PROD_W-1:0] sum;
    logic [FIDX_W-1:0] fidx;
    logic [SLOT_W-1:0] slot;

    assign o_dec_ready = !r_p_valid;
    assign move        = r_p_valid && (!r_o_valid || i_ready);
    assign accepted    = (r_p_dec.status == ST_ACCEPT);
    assign sum         = r_prod + PROD_W'(r_p_dec.freq);
    assign fidx        = accepted ? FIDX_W'(sum) : '0;
    assign slot        = accepted ? SLOT_W'(r_p_dec.slot) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_dec_valid && o_dec_ready) begin
                r_p_valid <= 1'b1;
            end else if (move) begin
                r_p_valid <= 1'b0;
            end
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dec_valid && o_dec_ready) begin
            r_p_dec <= i_dec;
            r_prod  <= PROD_W'(i_dec.slot) * PROD_W'(i_freq_count);
        end
        if (move) begin
            r_o_data <= OUT_DATA_W'({r_p_dec.wcount, r_p_dec.clear, fidx, slot});
            r_o_user <= r_p_dec.status;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_user  = r_o_user;

endmodule

`default_nettype wire

>>> design/time_slot_ring_allocator_top.sv
// Top level of the time slot ring allocator.
//
//  Channel   Direction  Ports                          Item
//  s_axis    in         s_axis_tvalid/tready/tdata     timestamp, freq_index
//  m_axis    out        m_axis_tvalid/tready/tdata/tuser  slot result, status
//  cfg       in         i_cfg_valid/o_cfg_ready/index/data  register write
//
// Items are taken one at a time: the next is taken only once the last has been scanned,
// reading every slot memory entry once through the single read port, and handed on.
// A result passes the decision register, the product register and the output register.
// After reset the slot memory is swept clear; no item is taken then, while configuration
// writes are always taken. A finished result waits in the output register while the next
// item is scanned; if the result side holds off, two results wait in the result stage and
// a third in the engine stops the input.
`default_nettype none

module time_slot_ring_allocator_top
    import tsra_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [63:0] timestamp, [73:64] freq_index, [79:74] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [8:0] slot, [27:9] frame_index, [28] clear_slot, [60:29] write_count, [63:61] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [1:0] status
    output logic [OUT_USER_W-1:0]      m_axis_tuser
);

    t_cfg cfg;
    t_dec dec;
    logic dec_valid;
    logic dec_ready;

    assign o_cfg_ready = 1'b1;

    tsra_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tsra_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_stamp     (s_axis_tdata[TS_W-1:0]),
        .i_freq      (s_axis_tdata[TS_W+FIN_W-1:TS_W]),
        .o_dec_valid (dec_valid),
        .i_dec_ready (dec_ready),
        .o_dec       (dec)
    );

    tsra_result u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_freq_count (cfg.freq_count),
        .i_dec_valid  (dec_valid),
        .o_dec_ready  (dec_ready),
        .i_dec        (dec),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_user       (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the time slot ring allocator: directed table, random traffic.
module testbench
    import tsra_pkg::*;
();

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 2 * (MAX_SLOTS + 6);
    localparam int HOLD_CYCLES   = 3000;
    localparam int HOLD_AT_FRAME = 300;
    localparam int PAUSE_AT_FRAME = 600;
    localparam logic [TS_W-1:0] TS_TOP = '1;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [FIDX_W-1:0] fidx;
        logic              clr;
        logic [WCNT_W-1:0] wcount;
    } t_slot_result;

    typedef enum bit {ROW_FRAME, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_data;
        logic [TS_W-1:0]        ts;
        logic [FIN_W-1:0]       freq;
        bit                     typed;
        t_slot_result           want;
    } t_stim_row;

    typedef struct {
        logic [SIU_W-1:0]  siu;
        logic [FCNT_W-1:0] fc;
        int                frames;
        logic [TS_W-1:0]   start_ts;
    } t_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // Predictor copy of the ring and the registers.
    logic [TS_W-1:0]   held_stamp [MAX_SLOTS];
    bit                held_valid [MAX_SLOTS];
    int                held_count = 0;
    logic [WCNT_W-1:0] writes_total = '0;
    logic [SIU_W-1:0]  ring_reg = SIU_W'(512);
    logic [FCNT_W-1:0] chan_reg = FCNT_W'(1024);

    t_slot_result pending_results[$];
    int  frames_sent = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 10;
    int  rx_idle_pct = 72;
    bit  rx_hold = 1'b0;

    time_slot_ring_allocator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    function automatic t_slot_result allocate_slot(input logic [TS_W-1:0] ts,
                                                   input logic [FIN_W-1:0] freq);
        t_slot_result    res;
        int              ring;
        int              pick;
        int              oldest;
        bit              seen;
        logic [TS_W-1:0] lo_t;
        logic [TS_W-1:0] hi_t;
        logic [31:0]     flat;
        res = '0;
        res.status = ST_ACCEPT;
        pick = -1;
        oldest = 0;
        seen = 1'b0;
        lo_t = '0;
        hi_t = '0;
        ring = (ring_reg == 0) ? 1 : (ring_reg > MAX_SLOTS) ? MAX_SLOTS : int'(ring_reg);
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (pick < 0 && held_valid[i] && held_stamp[i] == ts)
                pick = i;
        end
        if (pick < 0 && held_count < ring) begin
            // Lowest free slot below the ring size; one always exists here.
            pick = 0;
            for (int i = ring - 1; i >= 0; i--) begin
                if (!held_valid[i])
                    pick = i;
            end
            held_valid[pick] = 1'b1;
            held_stamp[pick] = ts;
            held_count++;
        end else if (pick < 0) begin
            // Full ring: the span of held stamps covers every valid slot, even above the ring size.
            for (int i = 0; i < MAX_SLOTS; i++) begin
                if (held_valid[i]) begin
                    if (!seen || held_stamp[i] < lo_t) begin
                        lo_t = held_stamp[i];
                        oldest = i;
                    end
                    if (!seen || held_stamp[i] > hi_t)
                        hi_t = held_stamp[i];
                    seen = 1'b1;
                end
            end
            if (ts < lo_t) begin
                res.status = ST_DROP_OLD;
            end else if (ts > hi_t) begin
                held_stamp[oldest] = ts;
                pick = oldest;
                res.clr = 1'b1;
            end else begin
                res.status = ST_DROP_IN;
            end
        end
        if (res.status == ST_ACCEPT) begin
            writes_total++;
            flat = pick * chan_reg + freq;
            res.slot = pick[SLOT_W-1:0];
            res.fidx = flat[FIDX_W-1:0];
        end
        res.wcount = writes_total;
        return res;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '{kind: ROW_CFG, cfg_idx: idx, cfg_data: data, ts: '0, freq: '0,
                typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_stim_row frame_row(input logic [TS_W-1:0] ts,
                                            input logic [FIN_W-1:0] freq);
        t_stim_row row;
        row = '{kind: ROW_FRAME, cfg_idx: '0, cfg_data: '0, ts: ts, freq: freq,
                typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_stim_row checked_row(input logic [TS_W-1:0] ts,
                                              input logic [FIN_W-1:0] freq,
                                              input t_status status,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [FIDX_W-1:0] fidx,
                                              input logic clr,
                                              input logic [WCNT_W-1:0] wcount);
        t_stim_row row;
        row = frame_row(ts, freq);
        row.typed = 1'b1;
        row.want = '{status: status, slot: slot, fidx: fidx, clr: clr, wcount: wcount};
        return row;
    endfunction

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_SLOTS_IN_USE)
            ring_reg = data[SIU_W-1:0];
        else if (idx == REG_FREQ_COUNT)
            chan_reg = data;
    endtask

    task automatic send_frame(input logic [TS_W-1:0] ts, input logic [FIN_W-1:0] freq,
                              input bit typed, input t_slot_result want);
        t_slot_result got;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        // The valid stays high from one item to the next unless a gap is taken or results are drained.
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - TS_W - FIN_W){1'b0}}, freq, ts};
        do @(posedge i_clk); while (!s_axis_tready);
        got = allocate_slot(ts, freq);
        pending_results.push_back(typed ? want : got);
        frames_sent++;
        tx_idle_pct = (frames_sent < 333) ? 10 : (frames_sent < 666) ? 72 : 0;
        rx_idle_pct <= (frames_sent < 333) ? 72 : (frames_sent < 666) ? 10 : 0;
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin : result_check
            t_slot_result want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                report_field("status", want.status, m_axis_tuser);
                report_field("slot", want.slot, m_axis_tdata[SLOT_W-1:0]);
                report_field("frame_index", want.fidx, m_axis_tdata[SLOT_W +: FIDX_W]);
                report_field("clear_slot", want.clr, m_axis_tdata[SLOT_W + FIDX_W]);
                report_field("write_count", want.wcount,
                             m_axis_tdata[SLOT_W + FIDX_W + 1 +: WCNT_W]);
            end
        end
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // One long stall of the result side, so the block fills up and stalls its input.
    initial begin
        wait (frames_sent >= HOLD_AT_FRAME);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("time_slot_ring_allocator_top test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row       dir_rows[$];
        t_phase          phases[$];
        logic [TS_W-1:0] ts_now;
        logic [TS_W-1:0] ts;
        int              pick;
        int              stride;

        // Small ring first: fill it, then drops on both sides, evictions and known stamps.
        dir_rows.push_back(checked_row(64'd100, 10'd0, ST_ACCEPT, 9'd0, 19'd0, 1'b0, 32'd1));
        dir_rows.push_back(cfg_row(REG_SLOTS_IN_USE, 11'd4));
        dir_rows.push_back(cfg_row(REG_FREQ_COUNT, 11'd3));
        dir_rows.push_back(frame_row(64'd200, 10'd5));
        dir_rows.push_back(frame_row(64'd100, 10'd1023));
        dir_rows.push_back(frame_row(64'd300, 10'd0));
        dir_rows.push_back(frame_row(64'd400, 10'd512));
        dir_rows.push_back(checked_row(64'd50, 10'd1, ST_DROP_OLD, 9'd0, 19'd0, 1'b0, 32'd5));
        dir_rows.push_back(checked_row(64'd250, 10'd2, ST_DROP_IN, 9'd0, 19'd0, 1'b0, 32'd5));
        dir_rows.push_back(frame_row(64'd400, 10'd0));
        dir_rows.push_back(frame_row(64'd500, 10'd7));
        dir_rows.push_back(checked_row(64'd0, 10'd0, ST_DROP_OLD, 9'd0, 19'd0, 1'b0, 32'd7));
        dir_rows.push_back(frame_row(64'h7FFF_FFFF_FFFF_FFFF, 10'd1023));
        dir_rows.push_back(frame_row(64'h7FFF_FFFF_FFFF_FFFF, 10'd341));
        dir_rows.push_back(frame_row(64'd300, 10'd682));
        // A ring size of zero acts as one; the held entries stay.
        dir_rows.push_back(cfg_row(REG_SLOTS_IN_USE, 11'd0));
        dir_rows.push_back(checked_row(64'd350, 10'd0, ST_DROP_IN, 9'd0, 19'd0, 1'b0, 32'd10));
        dir_rows.push_back(checked_row(64'd299, 10'd0, ST_DROP_OLD, 9'd0, 19'd0, 1'b0, 32'd10));
        dir_rows.push_back(cfg_row(REG_SLOTS_IN_USE, 11'd1023));
        dir_rows.push_back(cfg_row(REG_FREQ_COUNT, 11'd2047));
        dir_rows.push_back(checked_row(64'd1000, 10'd1023, ST_ACCEPT, 9'd4, 19'd9211, 1'b0,
                                       32'd11));
        dir_rows.push_back(cfg_row(REG_FREQ_COUNT, 11'd0));
        dir_rows.push_back(checked_row(64'd1000, 10'd1023, ST_ACCEPT, 9'd4, 19'd1023, 1'b0,
                                       32'd12));
        dir_rows.push_back(cfg_row(REG_FREQ_COUNT, 11'd1));
        dir_rows.push_back(frame_row(64'h8000_0000_0000_0000, 10'd0));
        // Shrunk below the entries held: only eviction of the oldest frees a slot.
        dir_rows.push_back(cfg_row(REG_SLOTS_IN_USE, 11'd5));
        dir_rows.push_back(frame_row(64'h8000_0000_0000_0001, 10'd3));

        phases.push_back('{siu: 10'd8, fc: 11'd1024, frames: 160, start_ts: '0});
        phases.push_back('{siu: 10'd1, fc: 11'd2047, frames: 120, start_ts: '0});
        phases.push_back('{siu: 10'd0, fc: 11'd1, frames: 80, start_ts: '0});
        phases.push_back('{siu: 10'd600, fc: 11'd0, frames: 120, start_ts: '0});
        phases.push_back('{siu: 10'd512, fc: 11'd2047, frames: 380, start_ts: '0});
        phases.push_back('{siu: 10'd3, fc: 11'd1023, frames: 120,
                           start_ts: 64'hFFFF_FFFF_FFFF_FF80});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_results();
                write_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_data);
            end else begin
                i_cfg_valid <= 1'b0;
                send_frame(dir_rows[r].ts, dir_rows[r].freq, dir_rows[r].typed,
                           dir_rows[r].want);
            end
        end

        // Mostly rising stamps repeated over channels, with stale and out-of-range noise.
        ts_now = 64'h8000_0000_0001_0000;
        foreach (phases[p]) begin
            drain_results();
            write_reg(REG_SLOTS_IN_USE, {1'($urandom_range(1)), phases[p].siu});
            write_reg(REG_FREQ_COUNT, phases[p].fc);
            i_cfg_valid <= 1'b0;
            if (phases[p].start_ts != 0)
                ts_now = phases[p].start_ts;
            repeat (phases[p].frames) begin
                if (frames_sent == PAUSE_AT_FRAME)
                    drain_results();
                pick = $urandom_range(99);
                if (pick < 55) begin
                    stride = $urandom_range(4, 1);
                    ts_now = (ts_now > TS_TOP - stride) ? TS_TOP : ts_now + stride;
                    ts = ts_now;
                end else if (pick < 80) begin
                    ts = ts_now - $urandom_range(6);
                end else if (pick < 92) begin
                    ts = ts_now - $urandom_range(20000);
                end else begin
                    ts = {1'b0, 31'($urandom), 32'($urandom)};
                end
                send_frame(ts, FIN_W'($urandom), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("time_slot_ring_allocator_top test passed");
        else
            $display("time_slot_ring_allocator_top test failed");
        $finish;
    end

endmodule
